// ===== rtl/ebc_pkg.sv =====
// expansion bus controller package: field widths, access mode codes, poll bits
// and the fixed read-id reply table
// no dependencies
package ebc_pkg;

  localparam int ModeW  = 4;
  localparam int ByteW  = 8;
  localparam int SlotW  = 4;
  localparam int ExtW   = 15;
  localparam int IdLen  = 12;

  // access modes
  localparam logic [ModeW-1:0] ModeSelWr  = 4'd0;
  localparam logic [ModeW-1:0] ModePollWr = 4'd1;
  localparam logic [ModeW-1:0] ModePollRd = 4'd2;
  localparam logic [ModeW-1:0] ModeCmdWr  = 4'd3;
  localparam logic [ModeW-1:0] ModeStsRd  = 4'd4;
  localparam logic [ModeW-1:0] ModeDataWr = 4'd5;
  localparam logic [ModeW-1:0] ModeDataRd = 4'd6;
  localparam logic [ModeW-1:0] ModeRsvRd  = 4'd7;
  localparam logic [ModeW-1:0] ModeTick   = 4'd8;

  // configuration register indexes
  localparam logic RegDevPresent = 1'b0;
  localparam logic RegLegacy     = 1'b1;

  // command and poll bits
  localparam logic [ByteW-1:0] CmdReadId   = 8'h83;
  localparam logic [ByteW-1:0] PollLegacy  = 8'h30;
  localparam logic [ByteW-1:0] NibbleMask  = 8'h0F;
  localparam int               PollClrFifo = 3;
  localparam int               PollClrRst  = 7;
  localparam int               SelMaskBit  = 7;
  localparam logic [3:0]       VldKeepRst  = 4'b1000;

  // read-id reply, byte by byte
  function automatic logic [ByteW-1:0] id_byte(input int idx);
    logic [ByteW-1:0] b;
    b = '0;
    if (idx == 0) b = CmdReadId;
    else if (idx == 2) b = 8'h10;
    else if (idx == 4) b = 8'h01;
    else if (idx == 11) b = 8'hE1;
    return b;
  endfunction

endpackage

// ===== rtl/ebc_req_if.sv =====
// request channel of the expansion bus controller: access mode and write byte
// depends on ebc_pkg
interface ebc_req_if import ebc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [ByteW-1:0] write_value;

  modport source (output valid, mode, write_value, input ready);
  modport sink (input valid, mode, write_value, output ready);
endinterface

// ===== rtl/ebc_rsp_if.sv =====
// result channel of the expansion bus controller: read byte and status flags
// depends on ebc_pkg
interface ebc_rsp_if import ebc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic             fiq_pulse;
  logic             to_device;
  logic             device_absent;

  modport source (output valid, read_data, fiq_pulse, to_device, device_absent, input ready);
  modport sink (input valid, read_data, fiq_pulse, to_device, device_absent, output ready);
endinterface

// ===== rtl/expansion_bus_controller_top.sv =====
// expansion bus controller, top level: request register, one pass of decode and
// state update, result register; apb-style configuration port
// depends on ebc_pkg, ebc_req_if, ebc_rsp_if
// a taken request passes through the request register and then the result register before its result is valid
// throughput: one request per cycle while results are taken, set by the single request register stage
// reset: asynchronous, clears slot select, valid bits, fifo counts and config;
// the three interrupt enables come up set
module expansion_bus_controller_top import ebc_pkg::*; #(
  parameter int CMD_LENGTH   = 7,
  parameter int STATUS_DEPTH = 12,
  parameter int NUM_SLOTS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ebc_req_if.sink     in_i,
  ebc_rsp_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [SlotW-1:0] BuiltinSlot = SlotW'(NUM_SLOTS - 1);
  localparam int CmdCntW = (CMD_LENGTH > 1) ? $clog2(CMD_LENGTH) : 1;
  localparam logic [CmdCntW-1:0] CmdLast = CmdCntW'(CMD_LENGTH - 1);
  localparam int StsCntW = $clog2(STATUS_DEPTH + 1);
  localparam logic [StsCntW-1:0] StsIdCnt = StsCntW'(IdLen);

  // configuration registers
  logic [ExtW-1:0] dev_present_q;
  logic            legacy_q;

  // request register
  logic             s1_valid_q;
  logic [ModeW-1:0] s1_mode_q;
  logic [ByteW-1:0] s1_val_q;

  // controller state
  logic [SlotW-1:0]   sel_q, sel_d;
  logic               hmask_q, hmask_d;
  logic [2:0]         en_q, en_d;
  logic [3:0]         vld_q, vld_d;
  logic [CmdCntW-1:0] cmd_cnt_q, cmd_cnt_d;
  logic [ByteW-1:0]   cmd_first_q;
  logic [StsCntW-1:0] sts_cnt_q, sts_cnt_d;
  logic [ByteW-1:0]   sts_q [STATUS_DEPTH];

  // result register
  logic             out_valid_q;
  logic [ByteW-1:0] rd_q, rd_d;
  logic             fiq_q, fiq_d;
  logic             fwd_q, fwd_d;
  logic             absent_q, absent_d;

  logic s1_move, s1_fire;
  logic builtin, dev, dev_next;
  logic cmd_first_wr, sts_load, sts_pop;
  logic [ByteW-1:0] cmd_first;
  logic [ExtW:0]    present_ext;

  // ---------------------------------------------------------------------------
  // configuration port: always ready, index taken from address bit 2
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLegacy) ? {31'b0, legacy_q}
                                          : {{(32 - ExtW){1'b0}}, dev_present_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_present_q <= '0;
      legacy_q      <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegDevPresent) dev_present_q <= pwdata[ExtW-1:0];
      else legacy_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the request register moves on whenever the result register is
  // empty or being taken, and while it does a new request enters every cycle
  // ---------------------------------------------------------------------------
  assign s1_move    = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && s1_move;
  assign in_i.ready = !s1_valid_q || s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_mode_q <= in_i.mode;
      s1_val_q  <= in_i.write_value;
    end
  end

  // ---------------------------------------------------------------------------
  // slot decode: slots at or above the built-in one never hold a device
  // ---------------------------------------------------------------------------
  assign present_ext = {1'b0, dev_present_q};
  assign builtin     = (sel_q == BuiltinSlot);
  assign dev         = (sel_q < BuiltinSlot) && present_ext[sel_q];
  assign dev_next    = (sel_d < BuiltinSlot) && present_ext[sel_d];

  // first command byte is the only one that decides what a command does
  assign cmd_first = (cmd_cnt_q == '0) ? s1_val_q : cmd_first_q;

  // ---------------------------------------------------------------------------
  // one pass of request decode and state update
  // ---------------------------------------------------------------------------
  always_comb begin
    sel_d        = sel_q;
    hmask_d      = hmask_q;
    en_d         = en_q;
    vld_d        = vld_q;
    cmd_cnt_d    = cmd_cnt_q;
    sts_cnt_d    = sts_cnt_q;
    cmd_first_wr = 1'b0;
    sts_load     = 1'b0;
    sts_pop      = 1'b0;
    rd_d         = '0;
    fiq_d        = 1'b0;
    // forwarded for the poll, command, status, data and reserved modes when an external device sits in the slot
    fwd_d = (s1_mode_q >= ModePollWr) && (s1_mode_q <= ModeRsvRd) && dev;

    unique case (s1_mode_q)
      ModeSelWr: begin
        sel_d   = s1_val_q[SlotW-1:0];
        hmask_d = s1_val_q[SelMaskBit];
      end
      ModePollWr: begin
        if (builtin) begin
          // bit 3 flushes both fifos and the status/data/message valids
          if (s1_val_q[PollClrFifo]) begin
            sts_cnt_d = '0;
            cmd_cnt_d = '0;
            vld_d     = vld_d & VldKeepRst;
          end
          if (s1_val_q[PollClrRst]) vld_d[3] = 1'b0;
          en_d  = s1_val_q[2:0];
          fiq_d = |(en_d & vld_d[2:0]);
        end
      end
      ModePollRd: begin
        if (builtin) rd_d = {vld_q, 1'b0, en_q};
        else if (!dev && legacy_q) rd_d = PollLegacy;
        if (hmask_q) rd_d = rd_d & NibbleMask;
      end
      ModeCmdWr: begin
        if (builtin) begin
          cmd_first_wr = (cmd_cnt_q == '0);
          if (cmd_cnt_q == CmdLast) begin
            // full command: execute and restart the fifo
            if (cmd_first == CmdReadId) begin
              sts_load  = 1'b1;
              sts_cnt_d = StsIdCnt;
              vld_d[0]  = 1'b1;
            end
            fiq_d     = |(en_q & vld_d[2:0]);
            cmd_cnt_d = '0;
          end else begin
            cmd_cnt_d = cmd_cnt_q + 1'b1;
          end
        end
      end
      ModeStsRd: begin
        if (builtin && (sts_cnt_q != '0)) begin
          rd_d      = sts_q[0];
          sts_pop   = 1'b1;
          sts_cnt_d = sts_cnt_q - 1'b1;
          // last byte gone: status no longer valid
          if (sts_cnt_q == StsCntW'(1)) vld_d[0] = 1'b0;
        end
      end
      ModeTick: begin
        fiq_d = builtin && (|(en_q & vld_q[2:0]));
      end
      default: begin
        // data accesses, reserved read and undefined modes leave state alone
      end
    endcase

    absent_d = (sel_d != BuiltinSlot) && !legacy_q && !dev_next;
  end

  // ---------------------------------------------------------------------------
  // controller state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= '0;
      hmask_q   <= 1'b0;
      en_q      <= 3'b111;
      vld_q     <= '0;
      cmd_cnt_q <= '0;
      sts_cnt_q <= '0;
    end else if (s1_fire) begin
      sel_q     <= sel_d;
      hmask_q   <= hmask_d;
      en_q      <= en_d;
      vld_q     <= vld_d;
      cmd_cnt_q <= cmd_cnt_d;
      sts_cnt_q <= sts_cnt_d;
    end
  end

  // first command byte, only read once written
  always_ff @(posedge clk_i) begin
    if (s1_fire && cmd_first_wr) cmd_first_q <= s1_val_q;
  end

  // status fifo as a shift line: head at entry 0, loaded in parallel on read-id
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STATUS_DEPTH; i++) begin
      if (s1_fire && sts_load) begin
        sts_q[i] <= (i < IdLen) ? id_byte(i) : '0;
      end else if (s1_fire && sts_pop) begin
        sts_q[i] <= (i < STATUS_DEPTH - 1) ? sts_q[(i + 1) % STATUS_DEPTH] : '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rd_q     <= rd_d;
      fiq_q    <= fiq_d;
      fwd_q    <= fwd_d;
      absent_q <= absent_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = rd_q;
  assign out_o.fiq_pulse     = fiq_q;
  assign out_o.to_device     = fwd_q;
  assign out_o.device_absent = absent_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // status valid bit tracks a non-empty status fifo
  a_sts_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] == (sts_cnt_q != '0))
    else $error("status valid bit out of step with fifo count");

  // status fifo never holds more than one read-id reply
  a_sts_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_cnt_q <= StsIdCnt)
    else $error("status fifo count beyond reply length");

  // interrupt only comes from the built-in unit, never with a forwarded access
  a_fiq_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.fiq_pulse |-> !out_o.to_device)
    else $error("interrupt raised on a forwarded access");
`endif

endmodule
